// File: src/hrme_pkg.sv
`timescale 1ns / 1ps
package hrme_pkg;
  localparam int MaxSamples = 1024;
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int CntW       = IdxW + 1;
  localparam int SampleW    = 32;
  localparam int DiffW      = SampleW + 1;
  localparam int BetaW      = 17;
  localparam logic [BetaW-1:0] BetaOne   = 17'h10000;
  localparam logic [BetaW-1:0] BetaReset = 17'h08000;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusUnsorted = 2'd2;
endpackage

// File: src/hrme_ram.sv
`timescale 1ns / 1ps
module hrme_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/half_range_mode_estimator.sv
`timescale 1ns / 1ps
// Half-range mode estimator. Sorted samples stream in on s_tdata, one per
// cycle while the block is loading, into a 1024-entry sample memory; s_tlast
// closes the set. The block then narrows a window by the half-range rule,
// reading the memory one word a cycle through its single read port. Each
// pass reads both window ends, then runs a two-pointer sweep over start
// and end points, and trims the ends when the window did not shrink. The
// result is twice the mode on m_tdata with a status code; samples past the
// 1024th are dropped and flagged, unsorted input gives status 2 and a zero
// mode. beta_q16 is written on the cfg channel while the block is idle.
module half_range_mode_estimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [32:0] mode_x2, [34:33] status, zero padding
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data   // beta_q16
);
  localparam int IW = hrme_pkg::IdxW;
  localparam int CW = hrme_pkg::CntW;
  localparam int SW = hrme_pkg::SampleW;
  localparam int DW = hrme_pkg::DiffW;
  localparam int BW = hrme_pkg::BetaW;

  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_RDLO  = 5'd1;
  localparam logic [4:0] ST_RDHI  = 5'd2;
  localparam logic [4:0] ST_SPAN  = 5'd3;
  localparam logic [4:0] ST_WCHK  = 5'd4;
  localparam logic [4:0] ST_BASE  = 5'd5;
  localparam logic [4:0] ST_BASEW = 5'd6;
  localparam logic [4:0] ST_EREQ  = 5'd7;
  localparam logic [4:0] ST_EW    = 5'd8;
  localparam logic [4:0] ST_FIN   = 5'd9;
  localparam logic [4:0] ST_TRIM  = 5'd10;
  localparam logic [4:0] ST_T1    = 5'd11;
  localparam logic [4:0] ST_T2    = 5'd12;
  localparam logic [4:0] ST_T3    = 5'd13;
  localparam logic [4:0] ST_T4    = 5'd14;
  localparam logic [4:0] ST_T5    = 5'd15;
  localparam logic [4:0] ST_DONE  = 5'd16;

  logic [4:0]          state;
  logic [BW-1:0]       beta_q16;
  logic [CW-1:0]       sample_count;
  logic [1:0]          error_flags;
  logic signed [SW-1:0] prev_sample;
  logic [IW-1:0]       window_low, window_high;
  logic [IW-1:0]       s_ptr, first, lastj, lo, hi;
  logic [CW-1:0]       e_ptr, best_count;
  logic [DW-1:0]       best_range, w;
  logic signed [SW-1:0] x_lo, base, prev_e, ta, tb, tc;
  logic [DW-1:0]       span;
  logic signed [DW-1:0] mode_x2;
  logic [1:0]          status;

  logic                ram_we;
  logic [IW-1:0]       ram_raddr;
  logic [SW-1:0]       ram_rdata;
  logic signed [SW-1:0] rd;

  assign rd        = signed'(ram_rdata);
  assign cfg_ready = (state == ST_LOAD);
  assign s_tready  = (state == ST_LOAD);

  logic accept;
  logic store_ok;
  logic res_take;
  assign accept   = s_tvalid && s_tready;
  assign store_ok = (sample_count < CW'(hrme_pkg::MaxSamples));
  assign ram_we   = accept && store_ok;
  assign res_take = (state == ST_DONE) && (!m_tvalid || m_tready);

  hrme_ram #(.Width(SW), .Depth(hrme_pkg::MaxSamples)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sample_count[IW-1:0]),
    .wdata (s_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read address per state; the read data comes back registered from the memory
  always_comb begin
    case (state)
      ST_RDLO:  ram_raddr = window_low;
      ST_RDHI:  ram_raddr = window_high;
      ST_BASE:  ram_raddr = s_ptr;
      ST_EREQ:  ram_raddr = e_ptr[IW-1:0];
      ST_T1:    ram_raddr = lo;
      ST_T2:    ram_raddr = lo + IW'(1);
      ST_T3:    ram_raddr = hi - IW'(1);
      ST_T4:    ram_raddr = hi;
      default:  ram_raddr = window_low;
    endcase
  end

  // Sweep helpers
  logic [BW-1:0]    beta_sat;
  logic [DW+BW-1:0] prod;
  logic [DW-1:0]    w_next;
  logic [DW-1:0]    diff_e, r_cur, dlo, dhi;
  logic [CW-1:0]    c_cur, hi_ext;
  logic [IW-1:0]    n_m1;
  assign beta_sat = (beta_q16 > hrme_pkg::BetaOne) ? hrme_pkg::BetaOne : beta_q16;
  assign prod     = span * beta_sat;
  assign w_next   = DW'(prod >> 16);
  assign diff_e   = DW'(DW'(signed'(rd)) - DW'(signed'(base)));
  assign c_cur    = e_ptr - CW'(s_ptr);
  assign r_cur    = DW'(DW'(signed'(prev_e)) - DW'(signed'(base)));
  assign n_m1     = window_high - window_low;
  assign hi_ext   = CW'(lastj) + best_count - CW'(1);
  assign dlo      = DW'(DW'(signed'(tb)) - DW'(signed'(ta)));
  assign dhi      = DW'(DW'(signed'(rd)) - DW'(signed'(tc)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      beta_q16     <= hrme_pkg::BetaReset;
      sample_count <= '0;
      error_flags  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) beta_q16 <= cfg_data;
      if (res_take)                  m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        // Load samples and check ordering
        ST_LOAD: begin
          if (accept) begin
            if (!store_ok) begin
              error_flags[0] <= 1'b1;
            end else begin
              if (sample_count != '0 && signed'(s_tdata) < prev_sample)
                error_flags[1] <= 1'b1;
              prev_sample  <= signed'(s_tdata);
              sample_count <= sample_count + CW'(1);
            end
            if (s_tlast) begin
              if (error_flags[1] ||
                  (store_ok && sample_count != '0 && signed'(s_tdata) < prev_sample)) begin
                mode_x2 <= '0;
                status  <= hrme_pkg::StatusUnsorted;
                state   <= ST_DONE;
              end else begin
                status      <= (error_flags[0] || !store_ok) ?
                               hrme_pkg::StatusOverflow : hrme_pkg::StatusOk;
                window_low  <= '0;
                window_high <= store_ok ? sample_count[IW-1:0]
                                        : IW'(sample_count - CW'(1));
                state       <= ST_RDLO;
              end
            end
          end
        end
        ST_RDLO: state <= ST_RDHI;
        ST_RDHI: begin
          x_lo  <= rd;
          state <= ST_SPAN;
        end
        // Window of one or two, else compute the width
        ST_SPAN: begin
          if (n_m1 == '0) begin
            mode_x2 <= DW'(signed'(x_lo)) <<< 1;
            state   <= ST_DONE;
          end else if (n_m1 == IW'(1)) begin
            mode_x2 <= DW'(signed'(x_lo)) + DW'(signed'(rd));
            state   <= ST_DONE;
          end else begin
            span  <= DW'(DW'(signed'(rd)) - DW'(signed'(x_lo)));
            state <= ST_WCHK;
          end
        end
        ST_WCHK: begin
          w <= w_next;
          if (w_next == '0) begin
            mode_x2 <= DW'(signed'(x_lo)) <<< 1;
            state   <= ST_DONE;
          end else begin
            best_count <= '0;
            best_range <= '0;
            first      <= window_low;
            lastj      <= window_low;
            s_ptr      <= window_low;
            e_ptr      <= CW'(window_low);
            state      <= ST_BASE;
          end
        end
        // Two-pointer sweep
        ST_BASE: state <= ST_BASEW;
        ST_BASEW: begin
          base  <= rd;
          state <= ST_EREQ;
        end
        ST_EREQ: begin
          if (e_ptr <= CW'(window_high)) state <= ST_EW;
          else                           state <= ST_FIN;
        end
        ST_EW: begin
          if (diff_e <= w) begin
            e_ptr  <= e_ptr + CW'(1);
            prev_e <= rd;
            state  <= ST_EREQ;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (c_cur > best_count) begin
            best_count <= c_cur;
            best_range <= r_cur;
            first      <= s_ptr;
            lastj      <= s_ptr;
          end else if (c_cur == best_count) begin
            if (r_cur < best_range) begin
              best_range <= r_cur;
              first      <= s_ptr;
              lastj      <= s_ptr;
            end else if (r_cur == best_range) begin
              lastj <= s_ptr;
            end
          end
          s_ptr <= s_ptr + IW'(1);
          if (e_ptr <= CW'(window_high)) state <= ST_BASE;
          else                           state <= ST_TRIM;
        end
        // New window; trim ends when it did not shrink
        ST_TRIM: begin
          if (hi_ext[IW-1:0] - first == n_m1) begin
            lo    <= first;
            hi    <= hi_ext[IW-1:0];
            state <= ST_T1;
          end else begin
            window_low  <= first;
            window_high <= hi_ext[IW-1:0];
            state       <= ST_RDLO;
          end
        end
        ST_T1: state <= ST_T2;
        ST_T2: begin
          ta    <= rd;
          state <= ST_T3;
        end
        ST_T3: begin
          tb    <= rd;
          state <= ST_T4;
        end
        ST_T4: begin
          tc    <= rd;
          state <= ST_T5;
        end
        ST_T5: begin
          window_low  <= (dlo >= dhi) ? lo + IW'(1) : lo;
          window_high <= (dlo <= dhi) ? hi - IW'(1) : hi;
          state       <= ST_RDLO;
        end
        // Hand the result to the output register
        ST_DONE: begin
          if (res_take) begin
            m_tdata      <= {5'd0, status, mode_x2};
            sample_count <= '0;
            error_flags  <= '0;
            state        <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int IdleLimit = 500000;
  localparam int HoldCycles = 3000;

  typedef struct packed {
    logic signed [hrme_pkg::SampleW-1:0] sample;
    logic                                last;
  } sample_req_t;

  typedef struct packed {
    logic [32:0] mode_x2;
    logic [1:0]  status;
  } mode_res_t;

  typedef enum int {SetSorted, SetShuffled, SetDropTail} set_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  half_range_mode_estimator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  sample_req_t pending_samples[$];
  mode_res_t   expected_modes[$];

  // predictor state
  logic signed [hrme_pkg::SampleW-1:0] sample_mem [hrme_pkg::MaxSamples];
  int          stored_count = 0;
  logic [1:0]  flag_bits = '0;
  logic [hrme_pkg::BetaW-1:0] beta_shadow = hrme_pkg::BetaReset;

  int  samples_taken = 0;
  int  driven_count = 0;
  int  modes_seen = 0;
  int  cfg_writes = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  int  sets_sent = 0;
  int  status_seen [3] = '{0, 0, 0};
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  no_gaps = 0;

  function automatic longint mem_at(int i);
    return longint'(sample_mem[i % hrme_pkg::MaxSamples]);
  endfunction

  // twice the half-range mode of the stored set
  function automatic longint half_range_x2();
    int lo, hi, n, s, e, first, lastj, c;
    longint bv, span, w, base, r, dlo, dhi, bc, br;
    bv = (beta_shadow > hrme_pkg::BetaOne) ? 65536 : longint'(beta_shadow);
    lo = 0;
    hi = stored_count - 1;
    forever begin
      n = hi - lo + 1;
      if (n == 1) return 2 * mem_at(lo);
      if (n == 2) return mem_at(lo) + mem_at(hi);
      span = mem_at(hi) - mem_at(lo);
      w = (span * bv) >> 16;
      if (w == 0) return 2 * mem_at(lo);
      bc = 0;
      br = 0;
      e = 0;
      first = 0;
      lastj = 0;
      for (s = 0; s < n && e < n; s++) begin
        base = mem_at(lo + s);
        while (e < n && (mem_at(lo + e) - base) <= w) e++;
        c = e - s;
        r = mem_at(lo + s + c - 1) - base;
        if (c > bc) begin
          bc = c; br = r; first = s; lastj = s;
        end else if (c == bc) begin
          if (r < br) begin
            br = r; first = s; lastj = s;
          end else if (r == br) begin
            lastj = s;
          end
        end
      end
      begin
        int nlo, nhi;
        nlo = lo + first;
        nhi = lo + lastj + int'(bc) - 1;
        // no shrink: trim the end(s) with the wider gap to the neighbour
        if (nhi - nlo + 1 == n) begin
          dlo = mem_at(nlo + 1) - mem_at(nlo);
          dhi = mem_at(nhi) - mem_at(nhi - 1);
          if (dlo <= dhi) nhi--;
          if (dlo >= dhi) nlo++;
        end
        lo = nlo;
        hi = nhi;
      end
    end
  endfunction

  // store one accepted sample; closes the set on last
  function automatic void absorb_sample(logic signed [hrme_pkg::SampleW-1:0] x,
                                        logic is_last);
    mode_res_t res;
    longint m;
    if (stored_count >= hrme_pkg::MaxSamples) begin
      flag_bits[0] = 1'b1;
    end else begin
      if (stored_count > 0 && longint'(x) < mem_at(stored_count - 1)) flag_bits[1] = 1'b1;
      sample_mem[stored_count] = x;
      stored_count++;
    end
    if (is_last) begin
      m = 0;
      if (flag_bits[1]) begin
        res.status = hrme_pkg::StatusUnsorted;
      end else begin
        res.status = flag_bits[0] ? hrme_pkg::StatusOverflow : hrme_pkg::StatusOk;
        m = half_range_x2();
      end
      res.mode_x2 = m[32:0];
      expected_modes.insert(expected_modes.size(), res);
      stored_count = 0;
      flag_bits = '0;
    end
  endfunction

  // monitor: tracks transfers on every channel, checks results, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      mode_res_t want;
      bit moved;
      moved = 0;
      if (cfg_valid && cfg_ready) begin
        beta_shadow = cfg_data;
        cfg_writes++;
        moved = 1;
      end
      if (s_tvalid && s_tready) begin
        absorb_sample(s_tdata, s_tlast);
        samples_taken++;
        moved = 1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1;
        modes_seen++;
        if (expected_modes.size() == 0) begin
          $display("%0t: unexpected result mode_x2=%0h status=%0d", $time,
                   m_tdata[32:0], m_tdata[34:33]);
          errors++;
        end else begin
          want = expected_modes.pop_front();
          if (m_tdata[34:33] <= 2) status_seen[m_tdata[34:33]]++;
          if (m_tdata[32:0] !== want.mode_x2) begin
            $display("%0t: mode_x2 expected %0h actual %0h", $time, want.mode_x2,
                     m_tdata[32:0]);
            errors++;
          end
          if (m_tdata[34:33] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_tdata[34:33]);
            errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no traffic for %0d cycles", IdleLimit);
        $display("half_range_mode_estimator: mismatch");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || driven_count < samples_taken) begin
        if (s_tvalid) driven_count++;
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_req_t it;
          it = pending_samples.pop_front();
          s_tdata  <= it.sample;
          s_tlast  <= it.last;
          s_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && samples_taken >= 300) begin
        hold_done = 1;
        hold_left = HoldCycles;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic add_set(int n, longint lo, int unsigned span, set_kind_t kind);
    longint vals[$];
    sample_req_t it;
    for (int i = 0; i < n; i++)
      vals.insert(vals.size(), lo + longint'($urandom_range(0, span)));
    if (kind != SetShuffled) vals.sort();
    // sorted run past the store, then a smaller sample in the dropped part
    if (kind == SetDropTail) vals.insert(vals.size(), lo - 1);
    foreach (vals[i]) begin
      it.sample = vals[i][31:0];
      it.last = (i == vals.size() - 1);
      pending_samples.insert(pending_samples.size(), it);
    end
    sets_sent++;
  endtask

  task automatic add_explicit(input longint v[]);
    sample_req_t it;
    foreach (v[i]) begin
      it.sample = v[i][31:0];
      it.last = (i == v.size() - 1);
      pending_samples.insert(pending_samples.size(), it);
    end
    sets_sent++;
  endtask

  task automatic random_sets(int items);
    int budget, n, p;
    longint lo;
    int unsigned span;
    budget = items;
    while (budget > 0) begin
      n = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      p = $urandom_range(0, 99);
      if (p < 30) begin
        lo = -64'sd2147483648;
        span = 32'hFFFF_FFFF;
      end else if (p < 70) begin
        span = $urandom_range(1, 1000);
        lo = longint'($signed($urandom)) - span;
        if (lo < -64'sd2147483648) lo = -64'sd2147483648;
      end else begin
        span = $urandom_range(0, 20);
        lo = longint'($signed($urandom_range(0, 2000))) - 1000;
      end
      add_set(n, lo, span, ($urandom_range(0, 99) < 10) ? SetShuffled : SetSorted);
      budget -= n;
    end
  endtask

  task automatic write_beta(logic [16:0] val);
    int before_w;
    @(negedge clk);
    before_w = cfg_writes;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    wait (cfg_writes != before_w);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !s_tvalid);
    wait (expected_modes.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [16:0] betas [6];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed sets at the reset beta
    add_explicit('{-64'sd2147483648});
    add_explicit('{64'sd2147483647});
    add_explicit('{-64'sd2147483648, 64'sd2147483647});
    add_explicit('{7, 7, 7, 7, 7});
    add_explicit('{-64'sd2147483648, 0, 64'sd2147483647});
    add_explicit('{5, 3, 9});
    add_explicit('{1, 2, 2, 3, 10, 11, 30});
    drain();
    random_sets(90);
    drain();

    betas = '{17'd0, hrme_pkg::BetaOne, 17'h1FFFF, 17'd1, 17'd16384, 17'd0};
    betas[5] = $urandom_range(2, 65535);
    foreach (betas[i]) begin
      write_beta(betas[i]);
      no_gaps = (i == 2);
      random_sets(100);
      drain();
    end

    wait (pending_samples.size() == 0 && !s_tvalid);
    wait (expected_modes.size() == 0);
    repeat (50) @(posedge clk);
    $display("ran %0d sets (%0d samples) over %0d beta writes; results %0d",
             sets_sent, samples_taken, cfg_writes, modes_seen);
    $display("status counts: ok %0d, overflow %0d, unsorted %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0 && expected_modes.size() == 0) begin
      $display("half_range_mode_estimator: match");
    end else begin
      $display("half_range_mode_estimator: mismatch");
    end
    $finish;
  end
endmodule
